>>> design/sdcmd_pkg.sv
// Shared types, constants and helper functions for the SD SPI command engine.
`timescale 1ns / 1ps

package sdcmd_pkg;

  // Byte values used on the SPI link.
  localparam logic [7:0] FILL_BYTE   = 8'hFF;
  localparam logic [7:0] START_BITS  = 8'h40;
  localparam logic [7:0] CRC_IDX0    = 8'h95;
  localparam logic [7:0] CRC_IDX8    = 8'h87;
  localparam logic [7:0] CRC_OTHER   = 8'h01;
  localparam logic [7:0] BUSY_BIT    = 8'h80;
  localparam logic [7:0] POLL_LIMIT_RESET = 8'd200;

  // Command indexes that carry a real CRC.
  localparam logic [5:0] CMD_GO_IDLE   = 6'd0;
  localparam logic [5:0] CMD_SEND_COND = 6'd8;

  // Frame layout: start byte, four argument bytes, CRC byte.
  localparam logic [2:0] FRAME_LAST = 3'd5;

  // Input kinds carried on the slave tuser.
  localparam logic ACT_START    = 1'b0;
  localparam logic ACT_EXCHANGE = 1'b1;

  // Configuration register address.
  localparam logic [1:0] ADDR_POLL_LIMIT = 2'd0;

  // Command phase, one-hot.
  typedef enum logic [5:0] {
    PH_IDLE    = 6'b000001,
    PH_WAIT    = 6'b000010,
    PH_FRAME   = 6'b000100,
    PH_POLL    = 6'b001000,
    PH_TRAIL   = 6'b010000,
    PH_TIMEOUT = 6'b100000
  } phase_t;

  // One result item, tx_byte in the lowest bits.
  typedef struct packed {
    logic [7:0] response;
    logic       status;
    logic       done_res;
    logic       chip_select;
    logic       tx_valid;
    logic [7:0] tx_byte;
  } out_item_t;

  localparam int OUT_ITEM_W = $bits(out_item_t);

  // Byte of the command frame at a given position.
  function automatic logic [7:0] frame_byte(input logic [2:0] pos,
                                            input logic [5:0] index,
                                            input logic [31:0] arg);
    logic [7:0] b;
    begin
      unique case (pos)
        3'd0: b = START_BITS | {2'b00, index};
        3'd1: b = arg[31:24];
        3'd2: b = arg[23:16];
        3'd3: b = arg[15:8];
        3'd4: b = arg[7:0];
        default: begin
          if (index == CMD_GO_IDLE) begin
            b = CRC_IDX0;
          end else if (index == CMD_SEND_COND) begin
            b = CRC_IDX8;
          end else begin
            b = CRC_OTHER;
          end
        end
      endcase
      return b;
    end
  endfunction

endpackage

>>> design/sdcmd_engine.sv
// Command sequencer: phase state and the per-transfer result logic.
`timescale 1ns / 1ps

module sdcmd_engine (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   step,
  input  logic                   action,
  input  logic [5:0]             cmd_index,
  input  logic [31:0]            argument,
  input  logic [7:0]             rx_byte,
  input  logic [7:0]             poll_limit,
  output sdcmd_pkg::out_item_t   result
);

  sdcmd_pkg::phase_t phase, phase_next;
  logic [2:0]  frame_position, frame_position_next;
  logic [7:0]  poll_count, poll_count_next;
  logic [5:0]  latched_index, latched_index_next;
  logic [31:0] latched_argument, latched_argument_next;
  logic [7:0]  latched_response, latched_response_next;
  logic [2:0]  pos_inc;
  logic [7:0]  poll_inc;

  assign pos_inc  = frame_position + 3'd1;
  assign poll_inc = poll_count + 8'd1;

  // Next state and result for the item in the input register.
  always_comb begin
    phase_next            = phase;
    frame_position_next   = frame_position;
    poll_count_next       = poll_count;
    latched_index_next    = latched_index;
    latched_argument_next = latched_argument;
    latched_response_next = latched_response;
    result                = '0;

    if (action == sdcmd_pkg::ACT_START) begin
      // A start aborts whatever is running.
      latched_index_next    = cmd_index;
      latched_argument_next = argument;
      latched_response_next = 8'd0;
      frame_position_next   = 3'd0;
      poll_count_next       = 8'd0;
      phase_next            = sdcmd_pkg::PH_WAIT;
      result.tx_byte        = sdcmd_pkg::FILL_BYTE;
      result.tx_valid       = 1'b1;
      result.chip_select    = 1'b1;
    end else begin
      unique case (phase)
        sdcmd_pkg::PH_WAIT: begin
          result.tx_valid    = 1'b1;
          result.chip_select = 1'b1;
          if (rx_byte == sdcmd_pkg::FILL_BYTE) begin
            phase_next          = sdcmd_pkg::PH_FRAME;
            frame_position_next = 3'd0;
            result.tx_byte      = sdcmd_pkg::frame_byte(3'd0, latched_index,
                                                        latched_argument);
          end else begin
            result.tx_byte = sdcmd_pkg::FILL_BYTE;
          end
        end
        sdcmd_pkg::PH_FRAME: begin
          result.tx_valid    = 1'b1;
          result.chip_select = 1'b1;
          if (frame_position != sdcmd_pkg::FRAME_LAST) begin
            frame_position_next = pos_inc;
            result.tx_byte      = sdcmd_pkg::frame_byte(pos_inc, latched_index,
                                                        latched_argument);
          end else begin
            frame_position_next = 3'd0;
            phase_next          = sdcmd_pkg::PH_POLL;
            poll_count_next     = 8'd0;
            result.tx_byte      = sdcmd_pkg::FILL_BYTE;
          end
        end
        sdcmd_pkg::PH_POLL: begin
          poll_count_next = poll_inc;
          // The limit check wins over a valid response on the same read.
          priority if (poll_inc == poll_limit) begin
            phase_next         = sdcmd_pkg::PH_TIMEOUT;
            result.chip_select = 1'b1;
            result.done_res    = 1'b1;
            result.status      = 1'b1;
          end else if ((rx_byte & sdcmd_pkg::BUSY_BIT) == 8'd0) begin
            latched_response_next = rx_byte;
            phase_next            = sdcmd_pkg::PH_TRAIL;
            result.tx_byte        = sdcmd_pkg::FILL_BYTE;
            result.tx_valid       = 1'b1;
          end else begin
            result.tx_byte     = sdcmd_pkg::FILL_BYTE;
            result.tx_valid    = 1'b1;
            result.chip_select = 1'b1;
          end
        end
        sdcmd_pkg::PH_TRAIL: begin
          phase_next      = sdcmd_pkg::PH_IDLE;
          result.done_res = 1'b1;
          result.response = latched_response;
        end
        sdcmd_pkg::PH_TIMEOUT: begin
          result.chip_select = 1'b1;
        end
        default: begin
          result = '0;
        end
      endcase
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= sdcmd_pkg::PH_IDLE;
      frame_position <= 3'd0;
      poll_count     <= 8'd0;
    end else if (step) begin
      phase          <= phase_next;
      frame_position <= frame_position_next;
      poll_count     <= poll_count_next;
    end
  end

  // Latched command and response.
  always_ff @(posedge clk) begin
    if (rst) begin
      latched_index    <= 6'd0;
      latched_argument <= 32'd0;
      latched_response <= 8'd0;
    end else if (step) begin
      latched_index    <= latched_index_next;
      latched_argument <= latched_argument_next;
      latched_response <= latched_response_next;
    end
  end

endmodule

>>> design/sdcmd_obuf.sv
// Two-entry result buffer that decouples the engine from the result receiver.
`timescale 1ns / 1ps

module sdcmd_obuf (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                push,
  input  logic [sdcmd_pkg::OUT_ITEM_W-1:0]    push_data,
  output logic                                full,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [sdcmd_pkg::OUT_ITEM_W-1:0]    out_data
);

  logic [sdcmd_pkg::OUT_ITEM_W-1:0] mem [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       pop;

  assign pop       = out_valid && out_ready;
  assign full      = (count == 2'd2);
  assign out_valid = (count != 2'd0);
  assign out_data  = mem[rd_ptr];

  // Storage write.
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  // Pointers and fill level.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      unique case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

>>> design/sd_spi_command_engine_unit.sv
// Top level of the SD SPI-mode command engine.
`timescale 1ns / 1ps
//
// Drives one SD-card SPI-mode command one byte exchange at a time.
// Slave stream: tuser is the action (0 start a command, 1 one exchange done);
// tdata carries cmd_index, argument and rx_byte. Each accepted transfer gives
// exactly one result transfer on the master stream: the next byte to send,
// whether another exchange is wanted, the chip select level, and on the last
// result the done flag, timeout status and R1 response.
// Path: the input register takes a transfer, the combinational sequencer step
// forms its result, and the result buffer takes that result, from which it is
// shown on the master side.
// Throughput is one item per cycle while the result buffer has room, set by the
// combinational sequencer step between those registers.
// The APB port writes and reads the response poll limit (address 0).
// Reset returns the phase to idle, clears the latched command and buffer, and
// restores the poll limit to 200. When the receiver stalls, the two-entry
// result buffer absorbs results; once it is full and the input register holds
// an item, s_tready drops until the receiver takes a result.

module sd_spi_command_engine_unit (
  input  logic        clk,
  input  logic        rst,
  // APB configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [1:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // Input stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [47:0] s_tdata,   // cmd_index[5:0], argument[37:6], rx_byte[45:38], zero
  input  logic        s_tuser,   // action[0]
  // Result stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata    // tx_byte[7:0], tx_valid[8], chip_select[9],
                                 // done_res[10], status[11], response[19:12], zero
);

  logic        poll_limit;
  logic [7:0]  response_poll_limit;
  logic        cfg_write;
  logic        in_valid;
  logic        in_action;
  logic [5:0]  in_cmd_index;
  logic [31:0] in_argument;
  logic [7:0]  in_rx_byte;
  logic        advance;
  logic        obuf_full;
  sdcmd_pkg::out_item_t result;
  logic [sdcmd_pkg::OUT_ITEM_W-1:0] obuf_data;

  // Configuration register.
  assign pready     = 1'b1;
  assign poll_limit = (paddr == sdcmd_pkg::ADDR_POLL_LIMIT);
  assign cfg_write  = psel && penable && pwrite && pready && poll_limit;
  assign prdata     = poll_limit ? {24'd0, response_poll_limit} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      response_poll_limit <= sdcmd_pkg::POLL_LIMIT_RESET;
    end else if (cfg_write) begin
      response_poll_limit <= pwdata[7:0];
    end
  end

  // Input register; it moves on whenever the result buffer has room.
  assign advance  = in_valid && !obuf_full;
  assign s_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_action    <= s_tuser;
      in_cmd_index <= s_tdata[5:0];
      in_argument  <= s_tdata[37:6];
      in_rx_byte   <= s_tdata[45:38];
    end
  end

  // Command sequencer.
  sdcmd_engine u_engine (
    .clk        (clk),
    .rst        (rst),
    .step       (advance),
    .action     (in_action),
    .cmd_index  (in_cmd_index),
    .argument   (in_argument),
    .rx_byte    (in_rx_byte),
    .poll_limit (response_poll_limit),
    .result     (result)
  );

  // Result buffer.
  sdcmd_obuf u_obuf (
    .clk       (clk),
    .rst       (rst),
    .push      (advance),
    .push_data (result),
    .full      (obuf_full),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_data  (obuf_data)
  );

  assign m_tdata = {{(24 - sdcmd_pkg::OUT_ITEM_W){1'b0}}, obuf_data};

endmodule

>>> design/sdcmd_checker.sv
// Port-level checks for the SD SPI command engine, bound to the top level.
`timescale 1ns / 1ps

module sdcmd_checker (
  input logic        clk,
  input logic        rst,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [23:0] m_tdata
);

  // A stalled result transfer holds.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result changed while stalled");

  // Reset empties the result buffer.
  a_reset: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid right after reset");

  // No byte is shown unless an exchange is requested.
  a_tx_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tdata[8] |-> m_tdata[7:0] == 8'd0)
    else $error("tx_byte nonzero without tx_valid");

  // Status and response stay clear until the command finishes.
  a_not_done: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tdata[10] |-> !m_tdata[11] && m_tdata[19:12] == 8'd0)
    else $error("status or response set before done");

  // A timeout ends with chip select held and no further exchange.
  a_timeout: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[10] && m_tdata[11] |-> m_tdata[9] && !m_tdata[8]
      && m_tdata[19:12] == 8'd0)
    else $error("timeout result malformed");

endmodule

bind sd_spi_command_engine_unit sdcmd_checker u_sdcmd_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
